/* sv/psd_pkg.sv */
// Shared types and constants for the price segment detector.
// No dependencies; imported by every other module of the block.

package psd_pkg;

   localparam int POSITION_BITS = 20;
   localparam int PRICE_BITS = 32;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int FIFO_COUNT_BITS = $clog2(FIFO_DEPTH + 1);
   localparam logic [FIFO_COUNT_BITS-1:0] FIFO_ROOM_MAX = FIFO_COUNT_BITS'(FIFO_DEPTH - 2);
   localparam logic [FIFO_COUNT_BITS-1:0] FIFO_FULL_COUNT = FIFO_COUNT_BITS'(FIFO_DEPTH);

   localparam logic [1:0] PIVOT_TOP = 2'b01;
   localparam logic [1:0] PIVOT_BOTTOM = 2'b11;

   localparam logic [1:0] MARK_CLEAR = 2'b00;
   localparam logic [1:0] MARK_TOP = 2'b01;
   localparam logic [1:0] MARK_BOTTOM = 2'b11;

   localparam logic [1:0] PUSH_NONE = 2'd0;
   localparam logic [1:0] PUSH_ONE = 2'd1;
   localparam logic [1:0] PUSH_TWO = 2'd2;

   typedef enum logic [2:0] {
      DIR_NONE = 3'b001,
      DIR_UP   = 3'b010,
      DIR_DOWN = 3'b100
   } dir_type;

   typedef struct packed {
      logic [POSITION_BITS-1:0] position;
      logic [1:0]               mark;
      logic                     last_of_run;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type item0;
      rsp_item_type item1;
   } psd_push_type;

endpackage

/* sv/psd_rsp_fifo.sv */
// Result queue: takes up to two results per cycle, hands out one per transfer.
// Depends on psd_pkg.

module psd_rsp_fifo
   import psd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  psd_push_type             push,
   output logic                     room,
   output logic [FIFO_COUNT_BITS-1:0] count,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [POSITION_BITS-1:0] rsp_position,
   output logic signed [1:0]        rsp_mark,
   output logic                     rsp_last_of_run
);

   rsp_item_type entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_COUNT_BITS-1:0] count_ff, count_in;
   logic [FIFO_PTR_BITS-1:0]   wr_next;
   logic                       pop;

   assign wr_next = wr_ptr_ff + FIFO_PTR_BITS'(1);
   assign pop = (count_ff != '0) && !rsp_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_BITS'(push.count);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_BITS'(pop);
      count_in = count_ff + FIFO_COUNT_BITS'(push.count) - FIFO_COUNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != PUSH_NONE) begin
         entry_ff[wr_ptr_ff] <= push.item0;
      end
      if (push.count == PUSH_TWO) begin
         entry_ff[wr_next] <= push.item1;
      end
   end

   assign room = (count_ff <= FIFO_ROOM_MAX);
   assign count = count_ff;
   assign rsp_valid = (count_ff != '0);
   assign rsp_position = entry_ff[rd_ptr_ff].position;
   assign rsp_mark = entry_ff[rd_ptr_ff].mark;
   assign rsp_last_of_run = entry_ff[rd_ptr_ff].last_of_run;

endmodule

/* sv/psd_core.sv */
// Bar input register, segment state and the single-pass update logic.
// Depends on psd_pkg; feeds psd_rsp_fifo through a psd_push_type.

module psd_core
   import psd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic                  csr_write_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic signed [1:0]     req_pivot_kind,
   input  logic [PRICE_BITS-1:0] req_bar_high,
   input  logic [PRICE_BITS-1:0] req_bar_low,
   input  logic                  req_end_of_series,
   input  logic                  room,
   output logic                  busy,
   output psd_push_type          push
);

   logic                     full_mode_ff;
   logic                     in_valid_ff, in_valid_in;
   logic [1:0]               kind_ff;
   logic [PRICE_BITS-1:0]    high_ff, low_ff;
   logic                     eos_ff;

   dir_type                  dir_ff, dir_in;
   logic                     seeded_ff, seeded_in;
   logic [POSITION_BITS-1:0] bar_pos_ff, bar_pos_in;
   logic [POSITION_BITS-1:0] top_pos_ff, top_pos_in;
   logic [POSITION_BITS-1:0] bot_pos_ff, bot_pos_in;
   logic [PRICE_BITS-1:0]    top_price_ff, top_price_in;
   logic [PRICE_BITS-1:0]    bot_price_ff, bot_price_in;
   logic [PRICE_BITS-1:0]    old_high_ff, old_high_in;
   logic [PRICE_BITS-1:0]    new_high_ff, new_high_in;
   logic [PRICE_BITS-1:0]    old_low_ff, old_low_in;
   logic [PRICE_BITS-1:0]    new_low_ff, new_low_in;
   logic [PRICE_BITS-1:0]    rt_high_ff, rt_high_in;
   logic [PRICE_BITS-1:0]    rt_low_ff, rt_low_in;

   logic accept, process;
   logic is_top, is_bot, all_set, up_pattern, down_pattern;
   logic go_top, go_bot, clear_old, set_rt_high, set_rt_low;
   logic [PRICE_BITS-1:0]    cur_top, cur_bot;
   logic [POSITION_BITS-1:0] clear_pos;
   logic [1:0]               new_mark;

   assign process = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign accept = req_valid && !req_stall;
   assign busy = in_valid_ff;
   assign in_valid_in = accept || (in_valid_ff && !process);

   always_ff @(posedge clock) begin
      if (reset) begin
         full_mode_ff <= 1'b1;
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_write_enable) begin
            full_mode_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_pivot_kind;
         high_ff <= req_bar_high;
         low_ff <= req_bar_low;
         eos_ff <= req_end_of_series;
      end
   end

   always_comb begin
      is_top = (kind_ff == PIVOT_TOP);
      is_bot = (kind_ff == PIVOT_BOTTOM);
      cur_top = seeded_ff ? top_price_ff : high_ff;
      cur_bot = seeded_ff ? bot_price_ff : low_ff;

      old_high_in = is_top ? new_high_ff : old_high_ff;
      new_high_in = is_top ? high_ff : new_high_ff;
      old_low_in = is_bot ? new_low_ff : old_low_ff;
      new_low_in = is_bot ? low_ff : new_low_ff;
      all_set = (old_high_in != '0) && (new_high_in != '0) &&
                (old_low_in != '0) && (new_low_in != '0);
      up_pattern = all_set && (new_high_in > old_high_in) && (new_low_in > old_low_in);
      down_pattern = all_set && (new_high_in < old_high_in) && (new_low_in < old_low_in);

      go_top = 1'b0;
      go_bot = 1'b0;
      clear_old = 1'b0;
      set_rt_high = 1'b0;
      set_rt_low = 1'b0;
      case (dir_ff)
         DIR_NONE: begin
            go_top = is_top;
            go_bot = is_bot;
         end
         DIR_UP: begin
            if (is_top) begin
               if (high_ff > cur_top) begin
                  clear_old = 1'b1;
                  go_top = 1'b1;
               end
            end else if (is_bot) begin
               if (low_ff < cur_bot || down_pattern) begin
                  go_bot = 1'b1;
               end else if (full_mode_ff) begin
                  if (rt_low_ff == '0) begin
                     set_rt_low = 1'b1;
                  end else if (low_ff < rt_low_ff) begin
                     go_bot = 1'b1;
                  end
               end
            end
         end
         DIR_DOWN: begin
            if (is_bot) begin
               if (low_ff < cur_bot) begin
                  clear_old = 1'b1;
                  go_bot = 1'b1;
               end
            end else if (is_top) begin
               if (high_ff > cur_top || up_pattern) begin
                  go_top = 1'b1;
               end else if (full_mode_ff) begin
                  if (rt_high_ff == '0) begin
                     set_rt_high = 1'b1;
                  end else if (high_ff > rt_high_ff) begin
                     go_top = 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase

      clear_pos = (dir_ff == DIR_UP) ? top_pos_ff : bot_pos_ff;
      new_mark = go_top ? MARK_TOP : MARK_BOTTOM;

      push.count = PUSH_NONE;
      push.item0 = '{position: bar_pos_ff, mark: new_mark, last_of_run: 1'b1};
      push.item1 = '{position: bar_pos_ff, mark: new_mark, last_of_run: 1'b1};
      if (process) begin
         if (clear_old) begin
            push.count = PUSH_TWO;
            push.item0 = '{position: clear_pos, mark: MARK_CLEAR, last_of_run: 1'b0};
         end else if (go_top || go_bot) begin
            push.count = PUSH_ONE;
         end
      end

      dir_in = dir_ff;
      top_pos_in = top_pos_ff;
      bot_pos_in = bot_pos_ff;
      top_price_in = cur_top;
      bot_price_in = cur_bot;
      rt_high_in = set_rt_high ? high_ff : rt_high_ff;
      rt_low_in = set_rt_low ? low_ff : rt_low_ff;
      if (go_top) begin
         dir_in = DIR_UP;
         top_pos_in = bar_pos_ff;
         top_price_in = high_ff;
         rt_high_in = '0;
         rt_low_in = '0;
      end
      if (go_bot) begin
         dir_in = DIR_DOWN;
         bot_pos_in = bar_pos_ff;
         bot_price_in = low_ff;
         rt_high_in = '0;
         rt_low_in = '0;
      end
      seeded_in = 1'b1;
      bar_pos_in = bar_pos_ff + POSITION_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset || (process && eos_ff)) begin
         dir_ff <= DIR_NONE;
         seeded_ff <= 1'b0;
         bar_pos_ff <= '0;
         top_pos_ff <= '0;
         bot_pos_ff <= '0;
         top_price_ff <= '0;
         bot_price_ff <= '0;
         old_high_ff <= '0;
         new_high_ff <= '0;
         old_low_ff <= '0;
         new_low_ff <= '0;
         rt_high_ff <= '0;
         rt_low_ff <= '0;
      end else if (process) begin
         dir_ff <= dir_in;
         seeded_ff <= seeded_in;
         bar_pos_ff <= bar_pos_in;
         top_pos_ff <= top_pos_in;
         bot_pos_ff <= bot_pos_in;
         top_price_ff <= top_price_in;
         bot_price_ff <= bot_price_in;
         old_high_ff <= old_high_in;
         new_high_ff <= new_high_in;
         old_low_ff <= old_low_in;
         new_low_ff <= new_low_in;
         rt_high_ff <= rt_high_in;
         rt_low_ff <= rt_low_in;
      end
   end

endmodule

/* sv/price_segment_detector_top.sv */
// Channel   Ports                                         Direction
// req       req_valid/req_stall, pivot, high, low, eos    bar in
// rsp       rsp_valid/rsp_stall, position, mark, last     mark event out
// csr       csr_write_enable/csr_write_data               retrace rule enable
//
// A bar is registered on transfer and processed in the next cycle if the result
// queue has two free slots; processing updates the state and pushes its results.
// Throughput is one bar per cycle unless stalled, limited to one result per cycle
// by the rsp port: a bar that moves an extreme (clear plus mark) gives two results.
// Synchronous active-high reset; retrace rule resets to enabled.
// Depends on psd_pkg, psd_core and psd_rsp_fifo.

module price_segment_detector_top
   import psd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic                     csr_write_data,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [1:0]        req_pivot_kind,
   input  logic [PRICE_BITS-1:0]    req_bar_high,
   input  logic [PRICE_BITS-1:0]    req_bar_low,
   input  logic                     req_end_of_series,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [POSITION_BITS-1:0] rsp_position,
   output logic signed [1:0]        rsp_mark,
   output logic                     rsp_last_of_run
);

   psd_push_type               push;
   logic                       room;
   logic                       busy;
   logic [FIFO_COUNT_BITS-1:0] count;

   psd_core u_core (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pivot_kind    (req_pivot_kind),
      .req_bar_high      (req_bar_high),
      .req_bar_low       (req_bar_low),
      .req_end_of_series (req_end_of_series),
      .room              (room),
      .busy              (busy),
      .push              (push)
   );

   psd_rsp_fifo u_fifo (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .room            (room),
      .count           (count),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_position    (rsp_position),
      .rsp_mark        (rsp_mark),
      .rsp_last_of_run (rsp_last_of_run)
   );

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count <= FIFO_FULL_COUNT)
      else $error("result queue overflow");

   a_clear_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_mark == MARK_CLEAR) |-> !rsp_last_of_run)
      else $error("clear result marked as last");

   a_stall_when_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (busy && !room))
      else $error("input stalled without a held bar");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      (push.count != PUSH_NONE) |-> room)
      else $error("result pushed without queue room");
`endif

endmodule
